### hw/rtl/avt_pkg.sv
// ----------------------------------------------------------------------------
// avt_pkg
// shared widths, register indexes and types for the aim velocity block
// ----------------------------------------------------------------------------
`default_nettype none

package avt_pkg;

  localparam int POS_W  = 16;
  localparam int SPD_W  = 16;
  localparam int BAND_W = 10;
  localparam int VEL_W  = 17;
  localparam int MAG_W  = 16;
  localparam int SQ_W   = 32;
  localparam int LEN_W  = 33;
  localparam int RHS_W  = 66;
  localparam int ACC_W  = 70;
  localparam int NSTG   = 16;
  localparam int CIDX_W = 1;
  localparam int CDAT_W = 16;

  typedef enum logic [CIDX_W-1:0] {
    CFG_SPEED = 1'b0,
    CFG_BAND  = 1'b1
  } avt_cfg_idx_t;

  typedef struct packed {
    logic aligned;
    logic xpos;
    logic ypos;
  } avt_side_t;

endpackage

`default_nettype wire

### hw/rtl/avt_ratio_pipe.sv
// ----------------------------------------------------------------------------
// avt_ratio_pipe
// one result bit per stage: largest m with (2m-1)^2 * len2 <= rhs,
// squares kept up to date by shifts and adds
// ----------------------------------------------------------------------------
`default_nettype none

module avt_ratio_pipe (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [avt_pkg::LEN_W-1:0]  len2,
  input  wire logic [avt_pkg::RHS_W-1:0]  rhs,
  output logic      [avt_pkg::MAG_W-1:0]  mag
);
  import avt_pkg::*;

  logic signed [ACC_W-1:0] p_r [NSTG-1];
  logic signed [ACC_W-1:0] q_r [NSTG-1];
  logic        [LEN_W-1:0] l_r [NSTG-1];
  logic        [RHS_W-1:0] r_r [NSTG-1];
  logic        [MAG_W-1:0] m_r [NSTG];

  for (genvar i = 0; i < NSTG; i++) begin : g_stg
    localparam int K = NSTG - 1 - i;
    logic signed [ACC_W-1:0] p_in, q_in, l_ext, cand, p_nxt, q_nxt;
    logic        [LEN_W-1:0] l_in;
    logic        [RHS_W-1:0] r_in;
    logic        [MAG_W-1:0] m_in, m_nxt;
    logic                    take;

    if (i == 0) begin : g_first
      assign l_in = len2;
      assign r_in = rhs;
      assign p_in = l_ext;
      assign q_in = -l_ext;
      assign m_in = '0;
    end else begin : g_next
      assign l_in = l_r[i-1];
      assign r_in = r_r[i-1];
      assign p_in = p_r[i-1];
      assign q_in = q_r[i-1];
      assign m_in = m_r[i-1];
    end

    assign l_ext = $signed({{(ACC_W-LEN_W){1'b0}}, l_in});
    assign cand  = p_in + (q_in <<< (K + 2)) + (l_ext <<< (2 * K + 2));
    assign take  = cand <= $signed({{(ACC_W-RHS_W){1'b0}}, r_in});
    assign p_nxt = take ? cand : p_in;
    assign q_nxt = take ? q_in + (l_ext <<< (K + 1)) : q_in;
    assign m_nxt = take ? (m_in | (MAG_W'(1) << K)) : m_in;

    always_ff @(posedge clk) begin
      if (en) begin
        m_r[i] <= m_nxt;
      end
    end

    if (i < NSTG - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          p_r[i] <= p_nxt;
          q_r[i] <= q_nxt;
          l_r[i] <= l_in;
          r_r[i] <= r_in;
        end
      end
    end
  end

  assign mag = m_r[NSTG-1];

endmodule

`default_nettype wire

### hw/rtl/aim_velocity_toward_target_top.sv
// ----------------------------------------------------------------------------
// aim_velocity_toward_target_top
// fixed speed velocity toward a target, Q8.8 rounded components
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_stall carries shooter centre, target corner and
//   target centre; output channel out_valid/out_stall returns vel_x, vel_y and
//   vertical_given, one result transaction per input transaction.
//   cfg_valid/cfg_ready writes speed (index 0) or align_band (index 1); the
//   port is always ready and is to be written only while the block is idle;
//   the block itself does not enforce this. pipeline: three set-up stages
//   (differences, squares, products), sixteen stages of the ratio search that
//   settle one result bit each, and the output register. throughput is one transaction per cycle while not stalled.
//   when the receiver stalls with a result waiting, the whole pipeline holds
//   and in_stall rises; nothing is dropped or repeated.
//   reset clears all valid bits and loads speed 256 and align_band 20.
// ----------------------------------------------------------------------------
`default_nettype none

module aim_velocity_toward_target_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [avt_pkg::POS_W-1:0]   in_src_x,
  input  wire logic [avt_pkg::POS_W-1:0]   in_src_y,
  input  wire logic [avt_pkg::POS_W-1:0]   in_tgt_x,
  input  wire logic [avt_pkg::POS_W-1:0]   in_tgt_y,
  input  wire logic [avt_pkg::POS_W-1:0]   in_tgt_mid_x,
  input  wire logic [avt_pkg::POS_W-1:0]   in_tgt_mid_y,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [avt_pkg::VEL_W-1:0] out_vel_x,
  output logic signed [avt_pkg::VEL_W-1:0] out_vel_y,
  output logic                             out_vertical_given,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [avt_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [avt_pkg::CDAT_W-1:0]  cfg_data
);
  import avt_pkg::*;

  logic              en;
  logic [SPD_W-1:0]  speed_r;
  logic [BAND_W-1:0] band_r;

  logic              v1_r, v2_r, v3_r, vo_r;
  logic [NSTG-1:0]   vp_r;
  avt_side_t         s1_r, s2_r, s3_r;
  avt_side_t         sp_r [NSTG];
  logic [MAG_W-1:0]  adx_r, ady_r;
  logic [SQ_W-1:0]   dx2_r, dy2_r, spd2_r;
  logic [LEN_W-1:0]  len2_r;
  logic [RHS_W-1:0]  rx_r, ry_r;
  logic [MAG_W-1:0]  mag_x, mag_y;

  logic signed [POS_W:0] dx, dy;
  logic [MAG_W-1:0]      adx_nxt, ady_nxt;
  avt_side_t             s1_nxt;
  logic [2*SQ_W-1:0]     px, py;
  logic [MAG_W-1:0]      mx_sel, my_sel;
  logic signed [VEL_W-1:0] vx_nxt, vy_nxt;

  assign en        = !vo_r || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= SPD_W'(256);
      band_r  <= BAND_W'(20);
    end else if (cfg_valid && cfg_ready) begin
      case (avt_cfg_idx_t'(cfg_index))
        CFG_SPEED: speed_r <= cfg_data[SPD_W-1:0];
        CFG_BAND:  band_r  <= cfg_data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // stage 1: differences, magnitudes, signs
  always_comb begin
    dx = $signed({in_tgt_x[POS_W-1], in_tgt_x}) - $signed({in_src_x[POS_W-1], in_src_x});
    dy = $signed({in_tgt_y[POS_W-1], in_tgt_y}) - $signed({in_src_y[POS_W-1], in_src_y});
    adx_nxt = dx[POS_W] ? MAG_W'(-dx) : MAG_W'(dx);
    ady_nxt = dy[POS_W] ? MAG_W'(-dy) : MAG_W'(dy);
    s1_nxt.aligned = ady_nxt <= {{(MAG_W-BAND_W){1'b0}}, band_r};
    s1_nxt.xpos    = $signed(in_src_x) < $signed(in_tgt_mid_x);
    s1_nxt.ypos    = $signed(in_src_y) < $signed(in_tgt_mid_y);
  end

  assign px = (2*SQ_W)'(spd2_r) * (2*SQ_W)'(dx2_r);
  assign py = (2*SQ_W)'(spd2_r) * (2*SQ_W)'(dy2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      adx_r  <= adx_nxt;
      ady_r  <= ady_nxt;
      s1_r   <= s1_nxt;
      dx2_r  <= adx_r * adx_r;
      dy2_r  <= ady_r * ady_r;
      spd2_r <= speed_r * speed_r;
      s2_r   <= s1_r;
      len2_r <= {1'b0, dx2_r} + {1'b0, dy2_r};
      rx_r   <= {px, 2'b00};
      ry_r   <= {py, 2'b00};
      s3_r   <= s2_r;
      sp_r[0] <= s3_r;
      for (int i = 1; i < NSTG; i++) begin
        sp_r[i] <= sp_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vp_r <= '0;
      vo_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      vp_r <= {vp_r[NSTG-2:0], v3_r};
      vo_r <= vp_r[NSTG-1];
    end
  end

  avt_ratio_pipe u_pipe_x (
    .clk  (clk),
    .en   (en),
    .len2 (len2_r),
    .rhs  (rx_r),
    .mag  (mag_x)
  );

  avt_ratio_pipe u_pipe_y (
    .clk  (clk),
    .en   (en),
    .len2 (len2_r),
    .rhs  (ry_r),
    .mag  (mag_y)
  );

  // output stage: aligned override and signs
  always_comb begin
    mx_sel = sp_r[NSTG-1].aligned ? speed_r : mag_x;
    my_sel = sp_r[NSTG-1].aligned ? '0 : mag_y;
    vx_nxt = sp_r[NSTG-1].xpos ? $signed({1'b0, mx_sel}) : -$signed({1'b0, mx_sel});
    vy_nxt = sp_r[NSTG-1].ypos ? $signed({1'b0, my_sel}) : -$signed({1'b0, my_sel});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_vel_x          <= vx_nxt;
      out_vel_y          <= vy_nxt;
      out_vertical_given <= !sp_r[NSTG-1].aligned;
    end
  end

  assign out_valid = vo_r;

  a_flat_no_vy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_vertical_given |-> out_vel_y == '0)
    else $error("aligned shot carries a vertical velocity");

  a_flat_speed : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_vertical_given |->
      out_vel_x == $signed({1'b0, speed_r}) || out_vel_x == -$signed({1'b0, speed_r}))
    else $error("aligned shot magnitude differs from speed");

  a_mag_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_vertical_given |->
      out_vel_x <= $signed({1'b0, speed_r}) && out_vel_x >= -$signed({1'b0, speed_r}))
    else $error("horizontal magnitude exceeds speed");

endmodule

`default_nettype wire
